FILE: rtl/cfhb_pkg.sv
package cfhb_pkg;

  localparam logic [31:0] CRC_POLY   = 32'hedb88320;
  localparam logic [7:0]  HDR_START  = 8'd1;
  localparam logic [63:0] SHORT_MAX  = 64'd125;
  localparam logic [63:0] MID_MAX    = 64'd65535;
  localparam logic [7:0]  CODE_MID   = 8'd126;
  localparam logic [7:0]  CODE_LONG  = 8'd127;
  localparam logic [3:0]  LAST_SHORT = 4'd6;
  localparam logic [3:0]  LAST_MID   = 4'd8;
  localparam logic [3:0]  LAST_LONG  = 4'd14;

  localparam logic [31:0] NIBBLE_TBL [16] = '{
    32'h00000000, 32'h1db71064, 32'h3b6e20c8, 32'h26d930ac,
    32'h76dc4190, 32'h6b6b51f4, 32'h4db26158, 32'h5005713c,
    CRC_POLY,     32'hf00f9344, 32'hd6d6a3e8, 32'hcb61b38c,
    32'h9b64c2b0, 32'h86d3d2d4, 32'ha00ae278, 32'hbdbdf21c
  };

  typedef struct packed {
    logic accept;
    logic hdr_step;
    logic pay_step;
    logic emit_step;
  } dp_cmd_t;

  typedef struct packed {
    logic hdr_done;
    logic emit_done;
    logic held_last;
    logic slot_free;
  } dp_stat_t;

  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] d);
    logic [31:0] c1;
    c1 = NIBBLE_TBL[c[3:0] ^ d[3:0]] ^ (c >> 4);
    return NIBBLE_TBL[c1[3:0] ^ d[7:4]] ^ (c1 >> 4);
  endfunction

  function automatic logic [3:0] hdr_last_idx(logic [63:0] len);
    logic [3:0] r;
    if (len > MID_MAX) r = LAST_LONG;
    else if (len > SHORT_MAX) r = LAST_MID;
    else r = LAST_SHORT;
    return r;
  endfunction

  function automatic logic [7:0] hdr_byte(logic [3:0] idx, logic [7:0] ftype,
                                          logic [63:0] len, logic [31:0] crc);
    logic long_len;
    logic [7:0] code;
    logic [7:0] r;
    long_len = (len > MID_MAX);
    if (long_len) code = CODE_LONG;
    else if (len > SHORT_MAX) code = CODE_MID;
    else code = len[7:0];
    unique case (idx)
      4'd0:  r = HDR_START;
      4'd1:  r = ftype;
      4'd2:  r = crc[31:24];
      4'd3:  r = crc[23:16];
      4'd4:  r = crc[15:8];
      4'd5:  r = crc[7:0];
      4'd6:  r = code;
      4'd7:  r = long_len ? len[63:56] : len[15:8];
      4'd8:  r = long_len ? len[55:48] : len[7:0];
      4'd9:  r = len[47:40];
      4'd10: r = len[39:32];
      4'd11: r = len[31:24];
      4'd12: r = len[23:16];
      4'd13: r = len[15:8];
      4'd14: r = len[7:0];
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/cfhb_dp.sv
module cfhb_dp
  import cfhb_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [7:0]  in_type,
  input  logic [7:0]  in_byte,
  input  logic [31:0] in_length,
  input  logic        in_first,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [3:0]  out_index,
  output logic        out_last
);

  logic [LENGTH_BITS-1:0] len;
  logic [7:0]             ftype;
  logic [31:0]            crc;
  logic [7:0]             pbyte;
  logic                   last_r;
  logic [3:0]             idx;
  logic [63:0]            in_len64;
  logic [63:0]            len64;
  logic [3:0]             last_idx;
  logic [7:0]             cur_byte;
  logic                   at_end;

  assign in_len64 = {32'd0, in_length};
  assign len64    = 64'(len);
  assign last_idx = hdr_last_idx(len64);
  assign at_end   = (idx == last_idx);
  assign cur_byte = hdr_byte(idx, ftype, len64, cmd.hdr_step ? 32'd0 : crc);

  assign stat.hdr_done  = at_end;
  assign stat.emit_done = at_end;
  assign stat.held_last = last_r;
  assign stat.slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      ftype     <= '0;
      crc       <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        pbyte  <= in_byte;
        last_r <= in_last;
        idx    <= '0;
        if (in_first) begin
          ftype <= in_type;
          len   <= in_len64[LENGTH_BITS-1:0];
          crc   <= '0;
        end else begin
          crc <= crc_byte(crc, in_byte);
        end
      end
      if (cmd.hdr_step) begin
        crc <= crc_byte(crc, cur_byte);
        idx <= at_end ? 4'd0 : idx + 4'd1;
      end
      if (cmd.pay_step) begin
        crc <= crc_byte(crc, pbyte);
        idx <= '0;
      end
      if (cmd.emit_step) begin
        out_valid <= 1'b1;
        idx       <= idx + 4'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      out_byte  <= cur_byte;
      out_index <= idx;
      out_last  <= at_end;
    end
  end

endmodule

FILE: rtl/cfhb_ctrl.sv
module cfhb_ctrl
  import cfhb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_first,
  input  logic     in_last,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HDR  = 2'd1;
  localparam logic [1:0] ST_PAY  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = !rst && (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          if (in_first) state_next = ST_HDR;
          else if (in_last) state_next = ST_EMIT;
        end
      end
      ST_HDR: begin
        cmd.hdr_step = 1'b1;
        if (stat.hdr_done) state_next = ST_PAY;
      end
      ST_PAY: begin
        cmd.pay_step = 1'b1;
        state_next   = stat.held_last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        cmd.emit_step = stat.slot_free;
        if (stat.slot_free && stat.emit_done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/crc32_frame_header_builder_unit.sv
// A byte without a first mark is folded into the CRC as it is accepted. A byte with a first mark
// starts a fold of n = 7, 9 or 15 header bytes into the CRC, one byte per cycle, and then the byte.
// A last byte adds n emission beats, one per cycle while m_tready is high; the first
// header beat is registered in the emit state after the payload byte is folded.
// Reset (rst, synchronous) clears the state machine, output valid, CRC, type and length.
module crc32_frame_header_builder_unit
  import cfhb_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // payload_byte [7:0], payload_length [39:8]
  input  logic [8:0]  s_tuser,   // frame_type [7:0], first [8]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // header_byte [7:0], header_index [11:8], zero [15:12]
  output logic        m_tlast
);

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [7:0] out_byte;
  logic [3:0] out_index;

  cfhb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_first (s_tuser[8]),
    .in_last  (s_tlast),
    .stat     (stat),
    .cmd      (cmd)
  );

  cfhb_dp #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_type   (s_tuser[7:0]),
    .in_byte   (s_tdata[7:0]),
    .in_length (s_tdata[39:8]),
    .in_first  (s_tuser[8]),
    .in_last   (s_tlast),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (out_byte),
    .out_index (out_index),
    .out_last  (m_tlast)
  );

  assign m_tdata = {4'd0, out_index, out_byte};

endmodule
